// ===== rtl/decimal_sum_accumulator_unit_assert.svh =====
// Assertion macros used by the decimal sum accumulator formatter.
`ifndef DECIMAL_SUM_ACCUMULATOR_UNIT_ASSERT_SVH
`define DECIMAL_SUM_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define DSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define DSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dsa_pkg.sv =====
// Shared types and character constants for the decimal sum accumulator.
package dsa_pkg;

	// One input item: a message byte and its end marker.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_message;
	} in_t;

	// One result item: a sum character or an error marker.
	typedef struct packed {
		logic [7:0] out_char;
		logic       status;
		logic       last;
	} out_t;

	// Flags of a finished message as handed from the parser to the formatter.
	typedef struct packed {
		logic err;
		logic neg;
	} job_flags_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Parser phases.
	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_MINUS  = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_BAD    = 5'b10000
	} phase_t;

	// Formatter states.
	typedef enum logic [5:0] {
		BK_IDLE  = 6'b000001,
		BK_LOAD  = 6'b000010,
		BK_CONV  = 6'b000100,
		BK_SKIP  = 6'b001000,
		BK_SIGN  = 6'b010000,
		BK_DIGIT = 6'b100000
	} bk_state_t;

endpackage

// ===== rtl/dsa_front.sv =====
// Message parser: checks each byte and hands finished messages to the queue.
module dsa_front import dsa_pkg::*; #(
	parameter int SUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output job_flags_t           push_flags,
	output logic [SUM_WIDTH-1:0] push_mag
);

	phase_t                 phase_q, phase_n;
	logic [SUM_WIDTH-1:0]   val_q, val_n;
	logic                   neg_q, neg_n;
	logic                   ended_q, ended_n;
	logic                   accept;
	logic                   is_nz, is_dig;
	logic [SUM_WIDTH-1:0]   digit_ext;

	// A byte is taken whenever the queue can absorb a possible finished message.
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Character classes.
	assign is_nz     = (in_data.in_byte >= CH_ONE) && (in_data.in_byte <= CH_NINE);
	assign is_dig    = (in_data.in_byte >= CH_ZERO) && (in_data.in_byte <= CH_NINE);
	assign digit_ext = {{(SUM_WIDTH-4){1'b0}}, in_data.in_byte[3:0]};

	// Parse step for the current byte.
	always_comb begin
		phase_n = phase_q;
		val_n   = val_q;
		neg_n   = neg_q;
		ended_n = ended_q;
		if (!ended_q) begin
			if (in_data.in_byte == CH_NUL) begin
				ended_n = 1'b1;
			end else begin
				unique case (phase_q)
					PH_START, PH_MINUS: begin
						priority if (phase_q == PH_START && in_data.in_byte == CH_MINUS) begin
							phase_n = PH_MINUS;
							neg_n   = 1'b1;
						end else if (in_data.in_byte == CH_ZERO) begin
							phase_n = PH_ZERO;
						end else if (is_nz) begin
							val_n   = digit_ext;
							phase_n = PH_DIGITS;
						end else begin
							phase_n = PH_BAD;
						end
					end
					PH_DIGITS: begin
						if (is_dig) begin
							val_n = (val_q << 3) + (val_q << 1) + digit_ext;
						end else begin
							phase_n = PH_BAD;
						end
					end
					default: begin
						phase_n = PH_BAD;
					end
				endcase
			end
		end
	end

	// A message is handed over on its final byte.
	assign push_valid     = accept && in_data.end_of_message;
	assign push_flags.err = !(phase_n == PH_ZERO || phase_n == PH_DIGITS);
	assign push_flags.neg = neg_n;
	assign push_mag       = val_n;

	// Parse state, cleared after each message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			val_q   <= '0;
			neg_q   <= 1'b0;
			ended_q <= 1'b0;
		end else if (accept) begin
			if (in_data.end_of_message) begin
				phase_q <= PH_START;
				val_q   <= '0;
				neg_q   <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				val_q   <= val_n;
				neg_q   <= neg_n;
				ended_q <= ended_n;
			end
		end
	end

endmodule

// ===== rtl/dsa_fifo.sv =====
// Two-entry queue between the parser and the formatter.
module dsa_fifo import dsa_pkg::*; #(
	parameter int SUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  job_flags_t           push_flags,
	input  logic [SUM_WIDTH-1:0] push_mag,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output job_flags_t           pop_flags,
	output logic [SUM_WIDTH-1:0] pop_mag
);

	job_flags_t           flags_q [2];
	logic [SUM_WIDTH-1:0] mag_q   [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_flags  = flags_q[rd_ptr_q];
	assign pop_mag    = mag_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			flags_q[wr_ptr_q] <= push_flags;
			mag_q[wr_ptr_q]   <= push_mag;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/dsa_back.sv =====
// Formatter: updates the running sum and prints it as decimal characters, or emits an error marker.
`include "decimal_sum_accumulator_unit_assert.svh"
module dsa_back import dsa_pkg::*; #(
	parameter int SUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  job_flags_t           job_flags,
	input  logic [SUM_WIDTH-1:0] job_mag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data
);

	// Decimal digits needed for the widest magnitude, and counter widths.
	localparam int ND = ((SUM_WIDTH * 1233) >> 12) + 1;
	localparam int BW = ND * 4;
	localparam int CW = $clog2(SUM_WIDTH + 1);
	localparam int RW = $clog2(ND + 1);

	bk_state_t            state_q;
	logic [SUM_WIDTH-1:0] sum_q;
	logic [SUM_WIDTH-1:0] mag_q;
	logic                 neg_q;
	logic [BW-1:0]        bcd_q;
	logic [CW-1:0]        bit_cnt_q;
	logic [RW-1:0]        rem_q;
	logic                 out_valid_q;
	out_t                 out_data_q;
	logic                 slot_free;
	logic                 take_job;
	logic                 load_out;
	out_t                 load_data;
	logic [3:0]           top_digit;
	logic [BW-1:0]        bcd_adj;

	// Add 3 to every BCD digit of five or more before the next shift.
	function automatic logic [BW-1:0] dabble_adj(input logic [BW-1:0] b);
		logic [BW-1:0] r;
		for (int i = 0; i < ND; i++) begin
			r[4*i +: 4] = (b[4*i +: 4] >= 4'd5) ? (b[4*i +: 4] + 4'd3) : b[4*i +: 4];
		end
		return r;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign job_ready = (state_q == BK_IDLE) && (!job_flags.err || slot_free);
	assign take_job  = job_valid && job_ready;
	assign top_digit = bcd_q[BW-1 -: 4];
	assign bcd_adj   = dabble_adj(bcd_q);

	// Result item to load into the output register.
	always_comb begin
		load_out  = 1'b0;
		load_data = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (take_job && job_flags.err) begin
					load_out           = 1'b1;
					load_data.out_char = CH_NUL;
					load_data.status   = 1'b1;
					load_data.last     = 1'b1;
				end
			end
			BK_SIGN: begin
				if (slot_free) begin
					load_out           = 1'b1;
					load_data.out_char = CH_MINUS;
				end
			end
			BK_DIGIT: begin
				if (slot_free) begin
					load_out           = 1'b1;
					load_data.out_char = CH_ZERO + {4'h0, top_digit};
					load_data.last     = (rem_q == RW'(1));
				end
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// Sequencer: sum update, bit-serial conversion, zero skip, emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			sum_q     <= '0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			bcd_q     <= '0;
			bit_cnt_q <= '0;
			rem_q     <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (take_job && !job_flags.err) begin
						sum_q   <= job_flags.neg ? (sum_q - job_mag) : (sum_q + job_mag);
						state_q <= BK_LOAD;
					end
				end
				BK_LOAD: begin
					neg_q     <= sum_q[SUM_WIDTH-1];
					mag_q     <= sum_q[SUM_WIDTH-1] ? (~sum_q + 1'b1) : sum_q;
					bcd_q     <= '0;
					bit_cnt_q <= CW'(SUM_WIDTH);
					state_q   <= BK_CONV;
				end
				BK_CONV: begin
					bcd_q     <= {bcd_adj[BW-2:0], mag_q[SUM_WIDTH-1]};
					mag_q     <= mag_q << 1;
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == CW'(1)) begin
						rem_q   <= RW'(ND);
						state_q <= BK_SKIP;
					end
				end
				BK_SKIP: begin
					if (top_digit == 4'h0 && rem_q > RW'(1)) begin
						bcd_q <= bcd_q << 4;
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= neg_q ? BK_SIGN : BK_DIGIT;
					end
				end
				BK_SIGN: begin
					if (slot_free) begin
						state_q <= BK_DIGIT;
					end
				end
				BK_DIGIT: begin
					if (slot_free) begin
						bcd_q <= bcd_q << 4;
						rem_q <= rem_q - 1'b1;
						if (rem_q == RW'(1)) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= load_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`DSA_ASSERT_IMP(a_digit_left, state_q == BK_DIGIT, rem_q != '0, "digit state with no digits left")
	`DSA_ASSERT_IMP(a_sign_neg, state_q == BK_SIGN, neg_q, "sign emitted for a non-negative sum")
	`DSA_ASSERT_NEXT(a_err_out, take_job && job_flags.err, out_valid_q && out_data_q.status && out_data_q.last, "error item not loaded")

endmodule

// ===== rtl/decimal_sum_accumulator_unit.sv =====
// Throughput: one byte per cycle while the two-entry queue has room. Once idle, the formatter
// takes a finished message from the queue, updates the sum, loads the magnitude, converts it to
// BCD bit-serially, skips leading zeros and registers the first result character; further
// characters follow one per cycle while the receiver keeps up. A valid message holds the
// formatter until its sign if negative and its digits (ND = 10 digits at 32 bits) are out; an
// invalid one only loads an error marker. Reset clears sum, parse state, queue and output valid.
module decimal_sum_accumulator_unit import dsa_pkg::*; #(
	parameter int SUM_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic                 push_valid, push_ready;
	job_flags_t           push_flags;
	logic [SUM_WIDTH-1:0] push_mag;
	logic                 pop_valid, pop_ready;
	job_flags_t           pop_flags;
	logic [SUM_WIDTH-1:0] pop_mag;

	// Parser.
	dsa_front #(.SUM_WIDTH(SUM_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_flags (push_flags),
		.push_mag   (push_mag)
	);

	// Queue of finished messages.
	dsa_fifo #(.SUM_WIDTH(SUM_WIDTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_flags (push_flags),
		.push_mag   (push_mag),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_flags  (pop_flags),
		.pop_mag    (pop_mag)
	);

	// Sum update and decimal output.
	dsa_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job_flags (pop_flags),
		.job_mag   (pop_mag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
